FILE: design/mean_and_covariance_assert.svh
// assertion macros for the mean and covariance block and its checker
// needs a clock named clk and an active-low reset named arst_n in scope
`ifndef MEAN_AND_COVARIANCE_ASSERT_SVH
`define MEAN_AND_COVARIANCE_ASSERT_SVH

// condition implies consequence in the same cycle
`define MAC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define MAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/mac_pkg.sv
// shared types and constants for the mean and covariance block
// no dependencies
package mac_pkg;
	localparam int MAX_SAMPLES_DEF = 1024;
	localparam int DIM_MAX_DEF = 8;
	localparam int COLS = 8;
	localparam int XW = 24;
	localparam int COVW = 50;
	localparam int ACCW = 64;
	localparam logic [3:0] DIM_RESET = 4'd8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM_RD,
		ST_SUM_ACC,
		ST_MEAN_LD,
		ST_MEAN_DIV,
		ST_ROW_RD,
		ST_ROW_LD,
		ST_COV_RD,
		ST_COV_WR,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_DIV,
		ST_EMIT
	} state_t;
endpackage

FILE: design/mac_ram.sv
// generic single-port synchronous ram with registered read
// no dependencies
module mac_ram #(
	parameter int W = 8,
	parameter int D = 16,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [W-1:0]  wdata,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: design/mean_and_covariance.sv
// top level: sample mean vector and population covariance matrix
// depends on mac_pkg and mac_ram
//
// usage
// - configuration: cfg_valid/cfg_ready/cfg_data write dim_count (ready is always high);
//   write it only while busy is low; it is latched at the first element of each set
// - input: a transaction is taken when start is high and busy is low, one element
//   per cycle; samples are stored in order, last_element closes the set
// - results: after the closing element busy rises and the block runs two passes
//   over the sample store, then emits one row per dimension, each marked by
//   result_valid for exactly one cycle; the receiver cannot stall, rows just go
// - pacing: after the closing element come the sum pass, the means, the covariance
//   pass and then the rows; all of it is set by the single store port, the single
//   accumulator ram port and the bit-serial divider
// - reset: arst_n clears the control state and sets dim_count to 8; the rams
//   need no clearing, the first sample of each pass overwrites the accumulators
// - samples past MAX_SAMPLES are dropped and reported on capacity_exceeded
module mean_and_covariance #(
	parameter int MAX_SAMPLES = mac_pkg::MAX_SAMPLES_DEF,
	parameter int DIM_MAX = mac_pkg::DIM_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic signed [23:0] sample_value,
	input  logic               last_element,
	output logic               result_valid,
	output logic [2:0]         row_index,
	output logic signed [23:0] mean_value,
	output logic signed [49:0] cov_col0,
	output logic signed [49:0] cov_col1,
	output logic signed [49:0] cov_col2,
	output logic signed [49:0] cov_col3,
	output logic signed [49:0] cov_col4,
	output logic signed [49:0] cov_col5,
	output logic signed [49:0] cov_col6,
	output logic signed [49:0] cov_col7,
	output logic               capacity_exceeded,
	output logic               last_row
);
	localparam int DEPTH = MAX_SAMPLES * DIM_MAX;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BW = $clog2(DEPTH + 1);
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int SW = mac_pkg::XW + CW;
	localparam int RW = CW + 1;
	localparam int ACCW = mac_pkg::ACCW;

	mac_pkg::state_t state_q, state_nx;

	// configuration and set bookkeeping
	logic [3:0]    dim_q;
	logic [3:0]    d_q;
	logic          open_q;
	logic [2:0]    pos_q;
	logic [CW-1:0] count_q;
	logic [BW-1:0] base_q;
	logic          dropped_q;

	// pass counters
	logic [CW-1:0] si_q;
	logic [BW-1:0] rbase_q;
	logic [2:0]    j_q;
	logic [2:0]    k_q;

	// per-dimension registers
	logic signed [SW-1:0]   sums_q [mac_pkg::COLS];
	logic signed [23:0]     mean_q [mac_pkg::COLS];
	logic signed [24:0]     dev_q  [mac_pkg::COLS];
	logic signed [49:0]     col_q  [mac_pkg::COLS];
	logic signed [24:0]     dj_q;
	logic signed [49:0]     prod_q;

	// bit-serial divider
	logic [RW-1:0]   rem_q;
	logic [ACCW-1:0] quo_q;
	logic            neg_q;
	logic [5:0]      dcnt_q;

	logic            accept;
	logic [3:0]      eff_dim;
	logic [3:0]      d_use;
	logic            room;
	logic            pos_wrap;
	logic            j_last;
	logic            k_last;
	logic            div_done;
	logic [RW-1:0]   rem_sh;
	logic            div_ge;
	logic [RW-1:0]   rem_nx;
	logic [ACCW-1:0] quo_nx;
	logic [ACCW-1:0] div_res;
	logic [BW-1:0]   wr_full;
	logic [BW-1:0]   rd_full;
	logic [2:0]      rd_idx;
	logic [2:0]      dev_idx;
	logic [2:0]      mean_idx;
	logic signed [24:0] dev_rd;
	logic signed [23:0] mean_rd;
	logic signed [24:0] dev_new;
	logic signed [ACCW-1:0] sum_ext;

	logic            st_we;
	logic [AW-1:0]   st_addr;
	logic [23:0]     st_rdata;
	logic            acc_we;
	logic [5:0]      acc_addr;
	logic [ACCW-1:0] acc_wdata;
	logic [ACCW-1:0] acc_rdata;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != mac_pkg::ST_IDLE);
	assign accept = start && !busy;

	// dim_count 0 acts as 1, values above DIM_MAX clamp
	always_comb begin
		eff_dim = dim_q;
		if (dim_q == 4'd0) begin
			eff_dim = 4'd1;
		end else if (32'(dim_q) > DIM_MAX) begin
			eff_dim = 4'(DIM_MAX);
		end
	end

	assign d_use    = open_q ? d_q : eff_dim;
	assign room     = (count_q < CW'(MAX_SAMPLES));
	assign pos_wrap = ((4'(pos_q) + 4'd1) >= d_use);
	assign j_last   = ((4'(j_q) + 4'd1) == d_q);
	assign k_last   = ((4'(k_q) + 4'd1) == d_q);
	assign div_done = (dcnt_q == 6'd63);

	// one restoring step per cycle on the magnitude
	assign rem_sh  = {rem_q[RW-2:0], quo_q[ACCW-1]};
	assign div_ge  = (rem_sh >= {1'b0, count_q});
	assign rem_nx  = div_ge ? (rem_sh - {1'b0, count_q}) : rem_sh;
	assign quo_nx  = {quo_q[ACCW-2:0], div_ge};
	assign div_res = (count_q == '0) ? '0 : (neg_q ? (~quo_nx + 1'b1) : quo_nx);

	assign wr_full  = base_q + BW'(pos_q);
	assign rd_idx   = (state_q == mac_pkg::ST_SUM_RD) ? j_q : k_q;
	assign rd_full  = rbase_q + BW'(rd_idx);
	assign dev_idx  = (state_q == mac_pkg::ST_COV_WR) ? (j_q + 3'd1) : k_q;
	assign dev_rd   = dev_q[dev_idx];
	assign mean_idx = (state_q == mac_pkg::ST_EMIT) ? j_q : k_q;
	assign mean_rd  = mean_q[mean_idx];
	assign dev_new  = 25'(signed'(st_rdata)) - 25'(mean_rd);
	assign sum_ext  = ACCW'(sums_q[j_q]);

	mac_ram #(.W(24), .D(DEPTH)) u_store (
		.clk   (clk),
		.we    (st_we),
		.addr  (st_addr),
		.wdata (sample_value),
		.rdata (st_rdata)
	);

	mac_ram #(.W(ACCW), .D(64)) u_acc (
		.clk   (clk),
		.we    (acc_we),
		.addr  (acc_addr),
		.wdata (acc_wdata),
		.rdata (acc_rdata)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			mac_pkg::ST_IDLE: begin
				if (accept && last_element) state_nx = mac_pkg::ST_SUM_RD;
			end
			mac_pkg::ST_SUM_RD: begin
				state_nx = (si_q == count_q) ? mac_pkg::ST_MEAN_LD : mac_pkg::ST_SUM_ACC;
			end
			mac_pkg::ST_SUM_ACC:  state_nx = mac_pkg::ST_SUM_RD;
			mac_pkg::ST_MEAN_LD:  state_nx = mac_pkg::ST_MEAN_DIV;
			mac_pkg::ST_MEAN_DIV: begin
				if (div_done) state_nx = j_last ? mac_pkg::ST_ROW_RD : mac_pkg::ST_MEAN_LD;
			end
			mac_pkg::ST_ROW_RD: begin
				state_nx = (si_q == count_q) ? mac_pkg::ST_OUT_RD : mac_pkg::ST_ROW_LD;
			end
			mac_pkg::ST_ROW_LD: begin
				state_nx = k_last ? mac_pkg::ST_COV_RD : mac_pkg::ST_ROW_RD;
			end
			mac_pkg::ST_COV_RD:   state_nx = mac_pkg::ST_COV_WR;
			mac_pkg::ST_COV_WR: begin
				state_nx = (k_last && j_last) ? mac_pkg::ST_ROW_RD : mac_pkg::ST_COV_RD;
			end
			mac_pkg::ST_OUT_RD:   state_nx = mac_pkg::ST_OUT_LD;
			mac_pkg::ST_OUT_LD:   state_nx = mac_pkg::ST_OUT_DIV;
			mac_pkg::ST_OUT_DIV: begin
				if (div_done) state_nx = k_last ? mac_pkg::ST_EMIT : mac_pkg::ST_OUT_RD;
			end
			mac_pkg::ST_EMIT: begin
				state_nx = j_last ? mac_pkg::ST_IDLE : mac_pkg::ST_OUT_RD;
			end
			default: state_nx = mac_pkg::ST_IDLE;
		endcase
	end

	// ram controls
	always_comb begin
		st_we     = 1'b0;
		st_addr   = rd_full[AW-1:0];
		acc_we    = 1'b0;
		acc_addr  = {j_q, k_q};
		acc_wdata = ((si_q == '0) ? '0 : acc_rdata) + ACCW'(prod_q);
		case (state_q)
			mac_pkg::ST_IDLE: begin
				st_we   = accept && room;
				st_addr = wr_full[AW-1:0];
			end
			mac_pkg::ST_COV_WR: acc_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mac_pkg::ST_IDLE;
			dim_q     <= mac_pkg::DIM_RESET;
			d_q       <= 4'd1;
			open_q    <= 1'b0;
			pos_q     <= '0;
			count_q   <= '0;
			base_q    <= '0;
			dropped_q <= 1'b0;
			si_q      <= '0;
			rbase_q   <= '0;
			j_q       <= '0;
			k_q       <= '0;
			dcnt_q    <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				dim_q <= cfg_data;
			end
			case (state_q)
				mac_pkg::ST_IDLE: begin
					if (accept) begin
						// latch the dimension at the first element of a set
						if (!open_q) begin
							d_q    <= eff_dim;
							open_q <= 1'b1;
						end
						if (!room) begin
							dropped_q <= 1'b1;
						end else if (pos_wrap) begin
							pos_q   <= '0;
							count_q <= count_q + 1'b1;
							base_q  <= base_q + BW'(DIM_MAX);
						end else begin
							pos_q <= pos_q + 3'd1;
						end
						if (last_element) begin
							si_q    <= '0;
							rbase_q <= '0;
							j_q     <= '0;
							k_q     <= '0;
						end
					end
				end
				mac_pkg::ST_SUM_ACC: begin
					if (j_last) begin
						j_q     <= '0;
						si_q    <= si_q + 1'b1;
						rbase_q <= rbase_q + BW'(DIM_MAX);
					end else begin
						j_q <= j_q + 3'd1;
					end
				end
				mac_pkg::ST_MEAN_LD:  dcnt_q <= '0;
				mac_pkg::ST_MEAN_DIV: begin
					dcnt_q <= dcnt_q + 6'd1;
					if (div_done) begin
						if (j_last) begin
							j_q     <= '0;
							k_q     <= '0;
							si_q    <= '0;
							rbase_q <= '0;
						end else begin
							j_q <= j_q + 3'd1;
						end
					end
				end
				mac_pkg::ST_ROW_LD: begin
					if (k_last) begin
						k_q <= '0;
						j_q <= '0;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				mac_pkg::ST_COV_WR: begin
					if (k_last) begin
						k_q <= '0;
						if (j_last) begin
							j_q     <= '0;
							si_q    <= si_q + 1'b1;
							rbase_q <= rbase_q + BW'(DIM_MAX);
						end else begin
							j_q <= j_q + 3'd1;
						end
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				mac_pkg::ST_OUT_LD:  dcnt_q <= '0;
				mac_pkg::ST_OUT_DIV: begin
					dcnt_q <= dcnt_q + 6'd1;
					if (div_done) begin
						k_q <= k_last ? 3'd0 : (k_q + 3'd1);
					end
				end
				mac_pkg::ST_EMIT: begin
					if (j_last) begin
						// set closed: back to an empty store
						j_q       <= '0;
						pos_q     <= '0;
						count_q   <= '0;
						base_q    <= '0;
						dropped_q <= 1'b0;
						open_q    <= 1'b0;
					end else begin
						j_q <= j_q + 3'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			mac_pkg::ST_IDLE: begin
				if (accept && last_element) begin
					for (int i = 0; i < mac_pkg::COLS; i++) begin
						sums_q[i] <= '0;
					end
				end
			end
			mac_pkg::ST_SUM_ACC: begin
				sums_q[j_q] <= sums_q[j_q] + SW'(signed'(st_rdata));
			end
			mac_pkg::ST_MEAN_LD: begin
				neg_q <= sum_ext[ACCW-1];
				quo_q <= sum_ext[ACCW-1] ? (~sum_ext + 1'b1) : sum_ext;
				rem_q <= '0;
			end
			mac_pkg::ST_MEAN_DIV: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				if (div_done) mean_q[j_q] <= div_res[23:0];
			end
			mac_pkg::ST_ROW_LD: begin
				dev_q[k_q] <= dev_new;
				if (k_last) dj_q <= (k_q == 3'd0) ? dev_new : dev_q[0];
			end
			mac_pkg::ST_COV_RD: begin
				prod_q <= dj_q * dev_rd;
			end
			mac_pkg::ST_COV_WR: begin
				if (k_last && !j_last) dj_q <= dev_rd;
			end
			mac_pkg::ST_OUT_LD: begin
				neg_q <= acc_rdata[ACCW-1];
				quo_q <= acc_rdata[ACCW-1] ? (~acc_rdata + 1'b1) : acc_rdata;
				rem_q <= '0;
			end
			mac_pkg::ST_OUT_DIV: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				if (div_done) col_q[k_q] <= div_res[49:0];
			end
			default: ;
		endcase
	end

	// result row, columns past the active dimension read as zero
	assign result_valid      = (state_q == mac_pkg::ST_EMIT);
	assign row_index         = j_q;
	assign mean_value        = mean_rd;
	assign capacity_exceeded = dropped_q;
	assign last_row          = j_last;
	assign cov_col0 = (d_q > 4'd0) ? col_q[0] : '0;
	assign cov_col1 = (d_q > 4'd1) ? col_q[1] : '0;
	assign cov_col2 = (d_q > 4'd2) ? col_q[2] : '0;
	assign cov_col3 = (d_q > 4'd3) ? col_q[3] : '0;
	assign cov_col4 = (d_q > 4'd4) ? col_q[4] : '0;
	assign cov_col5 = (d_q > 4'd5) ? col_q[5] : '0;
	assign cov_col6 = (d_q > 4'd6) ? col_q[6] : '0;
	assign cov_col7 = (d_q > 4'd7) ? col_q[7] : '0;
endmodule

FILE: design/mac_checker.sv
// port-level checker for the mean and covariance block, bound to the top level
// depends on mean_and_covariance_assert.svh
`include "mean_and_covariance_assert.svh"

module mac_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        last_element,
	input logic        result_valid,
	input logic        last_row
);
	`MAC_ASSERT_SAME(a_row_while_busy, result_valid, busy, "result row while idle")
	`MAC_ASSERT_NEXT(a_rows_spaced, result_valid && !last_row, !result_valid && busy, "rows back to back")
	`MAC_ASSERT_NEXT(a_idle_after_last, result_valid && last_row, !busy, "still busy after last row")
	`MAC_ASSERT_NEXT(a_busy_after_close, start && !busy && last_element, busy, "no compute after closing element")
endmodule

bind mean_and_covariance mac_port_checker u_mac_checker (.*);

FILE: test/mac_checker.sv
// checker for mean_and_covariance: predicts result rows from observed transactions
// depends on mac_pkg; instantiated by tb_top beside the block
`timescale 1ns / 1ps

module mac_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [3:0]         cfg_data,
	input  logic               start,
	input  logic               busy,
	input  logic signed [23:0] sample_value,
	input  logic               last_element,
	input  logic               result_valid,
	input  logic [2:0]         row_index,
	input  logic signed [23:0] mean_value,
	input  logic signed [49:0] cov_col0,
	input  logic signed [49:0] cov_col1,
	input  logic signed [49:0] cov_col2,
	input  logic signed [49:0] cov_col3,
	input  logic signed [49:0] cov_col4,
	input  logic signed [49:0] cov_col5,
	input  logic signed [49:0] cov_col6,
	input  logic signed [49:0] cov_col7,
	input  logic               capacity_exceeded,
	input  logic               last_row,
	output int                 fail_count,
	output int                 rows_pending,
	output int                 rows_seen
);
	localparam int CAP = mac_pkg::MAX_SAMPLES_DEF;
	localparam int DMAX = mac_pkg::DIM_MAX_DEF;

	typedef struct packed {
		logic [2:0]            row;
		logic [23:0]           mean;
		logic [7:0][49:0]      cov;
		logic                  cap;
		logic                  last;
	} cov_row_t;

	cov_row_t expected_rows[$];

	logic signed [23:0] sample_mem [CAP*DMAX];
	logic [3:0] dim_reg;
	int elem_pos, n_samples, set_dim;
	bit set_open, dropped;

	function automatic int clamp_dim(logic [3:0] v);
		if (v == 0) return 1;
		if (v > DMAX) return DMAX;
		return int'(v);
	endfunction

	// two passes over the stored samples, then one row per dimension
	task automatic close_set();
		longint sums [8];
		longint mean [8];
		longint acc [64];
		longint dj, dk, c;
		cov_row_t r;
		for (int j = 0; j < 8; j++) begin
			sums[j] = 0;
			mean[j] = 0;
		end
		for (int j = 0; j < 64; j++) acc[j] = 0;
		for (int i = 0; i < n_samples; i++)
			for (int j = 0; j < set_dim; j++)
				sums[j] += longint'(sample_mem[i*DMAX + j]);
		if (n_samples > 0)
			for (int j = 0; j < set_dim; j++) mean[j] = sums[j] / longint'(n_samples);
		for (int i = 0; i < n_samples; i++)
			for (int j = 0; j < set_dim; j++) begin
				dj = longint'(sample_mem[i*DMAX + j]) - mean[j];
				for (int k = 0; k < set_dim; k++) begin
					dk = longint'(sample_mem[i*DMAX + k]) - mean[k];
					acc[j*8 + k] += dj * dk;
				end
			end
		for (int j = 0; j < set_dim; j++) begin
			r.row = j[2:0];
			r.mean = mean[j][23:0];
			for (int k = 0; k < 8; k++) begin
				c = 0;
				if (k < set_dim && n_samples > 0) c = acc[j*8 + k] / longint'(n_samples);
				r.cov[k] = c[49:0];
			end
			r.cap = dropped;
			r.last = (j + 1 == set_dim);
			expected_rows.push_back(r);
		end
		elem_pos = 0;
		n_samples = 0;
		dropped = 0;
		set_open = 0;
	endtask

	task automatic take_element(logic signed [23:0] x, logic fin);
		if (!set_open) begin
			set_dim = clamp_dim(dim_reg);
			set_open = 1;
		end
		if (n_samples >= CAP) begin
			dropped = 1;
		end else begin
			sample_mem[n_samples*DMAX + elem_pos] = x;
			if (elem_pos + 1 >= set_dim) begin
				elem_pos = 0;
				n_samples++;
			end else begin
				elem_pos++;
			end
		end
		if (fin) close_set();
	endtask

	task automatic check_row();
		cov_row_t got, exp_r;
		got.row = row_index;
		got.mean = mean_value;
		got.cov = {cov_col7, cov_col6, cov_col5, cov_col4,
			cov_col3, cov_col2, cov_col1, cov_col0};
		got.cap = capacity_exceeded;
		got.last = last_row;
		rows_seen++;
		if (expected_rows.size() == 0) begin
			fail_count++;
			if (fail_count <= 10) $display("unexpected result row %0d", got.row);
			return;
		end
		exp_r = expected_rows.pop_front();
		if (got !== exp_r) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("row mismatch: row exp %0d got %0d, mean exp %h got %h",
					exp_r.row, got.row, exp_r.mean, got.mean);
				for (int k = 0; k < 8; k++)
					if (got.cov[k] !== exp_r.cov[k])
						$display("  cov col %0d exp %h got %h", k, exp_r.cov[k], got.cov[k]);
				$display("  capacity exp %b got %b, last_row exp %b got %b",
					exp_r.cap, got.cap, exp_r.last, got.last);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_reg = mac_pkg::DIM_RESET;
			elem_pos = 0;
			n_samples = 0;
			set_dim = 1;
			set_open = 0;
			dropped = 0;
			fail_count = 0;
			rows_seen = 0;
			expected_rows.delete();
		end else begin
			if (cfg_valid && cfg_ready) dim_reg = cfg_data;
			if (start && !busy) take_element(sample_value, last_element);
			if (result_valid) check_row();
		end
		rows_pending = expected_rows.size();
	end
endmodule

FILE: test/tb_top.sv
// testbench top for mean_and_covariance: clock, reset, stimulus and verdict
// depends on mac_pkg, mean_and_covariance and mac_checker
`timescale 1ns / 1ps

module tb_top;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [3:0] cfg_data;
	logic start, busy;
	logic signed [23:0] sample_value;
	logic last_element;
	logic result_valid;
	logic [2:0] row_index;
	logic signed [23:0] mean_value;
	logic signed [49:0] cov_col0, cov_col1, cov_col2, cov_col3;
	logic signed [49:0] cov_col4, cov_col5, cov_col6, cov_col7;
	logic capacity_exceeded, last_row;
	int fail_count, rows_pending, rows_seen;

	// sender idles this many times in a hundred
	int idle_pct;
	int items_sent, sets_sent;
	longint cycles;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	mean_and_covariance dut (.*);

	mac_checker chk (.*);

	// watchdog: ends a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// one input transaction, always entered and left at a falling edge
	task automatic send(logic signed [23:0] v, logic fin);
		while (busy || ($urandom_range(99) < idle_pct)) begin
			start = 1'b0;
			sample_value = 24'($urandom);
			last_element = 1'($urandom);
			@(negedge clk);
		end
		start = 1'b1;
		sample_value = v;
		last_element = fin;
		items_sent++;
		if (fin) sets_sent++;
		@(negedge clk);
	endtask

	// hold off until every row of the last set has come and the block is idle
	task automatic drain();
		start = 1'b0;
		@(negedge clk);
		while (busy || rows_pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_dim(logic [3:0] v);
		start = 1'b0;
		cfg_valid = 1'b1;
		cfg_data = v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic signed [23:0] rand_value();
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return 24'($signed($urandom_range(511)) - 256);
			2: return $urandom_range(1) ? 24'sh7fffff : -24'sh800000;
			default: return 24'($signed($urandom_range(65535)) - 32768);
		endcase
	endfunction

	// one data set of n whole samples plus an optional partial tail
	task automatic send_set(int d, int n, int tail);
		int total;
		total = n * d + tail;
		for (int i = 0; i < total; i++) send(rand_value(), i == total - 1);
	endtask

	initial begin
		int d, n, tail;
		cycles = 0;
		items_sent = 0;
		sets_sent = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		start = 1'b0;
		sample_value = '0;
		last_element = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset dimension with extreme values
		send(24'sh7fffff, 1'b0);
		for (int i = 1; i < 8; i++) send(-24'sh800000, 1'b0);
		for (int i = 0; i < 7; i++) send(24'sh7fffff, 1'b0);
		send(-24'sh800000, 1'b1);
		drain();

		// dimension 0 acts as one, single closing element
		write_dim(4'd0);
		send(-24'sh800000, 1'b0);
		send(24'sh7fffff, 1'b1);
		drain();

		// dimension above range acts as eight, with a partial tail
		write_dim(4'd15);
		send_set(8, 1, 3);
		drain();

		// zero samples: only a partial sample before the close
		write_dim(4'd3);
		send(24'sh000100, 1'b0);
		send(-24'sh000100, 1'b1);
		drain();

		// dimension changed mid-set: the latched value holds
		send(24'sh001000, 1'b0);
		write_dim(4'd5);
		send(24'sh002000, 1'b0);
		send(-24'sh003000, 1'b1);
		drain();

		// random sets in three idle phases
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 29 : (ph == 1) ? 51 : 0;
			for (int s = 0; s < 8; s++) begin
				write_dim(4'($urandom_range(15)));
				d = $urandom_range(1, 8);
				write_dim(4'(d));
				n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
				tail = ($urandom_range(3) == 0) ? $urandom_range(d - 1) : 0;
				if (n == 0 && tail == 0) tail = 1;
				send_set(d, n, tail);
				if ($urandom_range(1)) drain();
				else begin
					start = 1'b0;
					@(negedge clk);
					while (busy || rows_pending != 0) @(negedge clk);
				end
			end
		end
		write_dim(4'd8);

		drain();
		repeat (50) @(negedge clk);
		$display("covered %0d element transactions in %0d data sets, %0d result rows",
			items_sent, sets_sent, rows_seen);
		$display("dimensions 0 to 15, mid-set changes, empty sets, partial tails, idle phases");
		if (fail_count == 0 && rows_pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
